// File: sv/bfrl_pkg.sv
// ----------------------------------------------------------------------------
// bfrl_pkg
// Types and constants shared by the token run-length loop labeler: the item
// structs of both channels, command and character codes, and stack control.
// ----------------------------------------------------------------------------
package bfrl_pkg;

    // input item: one program byte plus end marker
    typedef struct packed {
        logic [7:0] character;
        logic       is_end;
    } t_in_item;

    // result item: one command token
    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] count;
        logic [15:0] label;
        logic        error;
        logic        last;
    } t_out_item;

    // stack control and status between the top level and the label stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_status;

    // token opcodes
    localparam logic [3:0] OP_INC   = 4'd0;
    localparam logic [3:0] OP_DEC   = 4'd1;
    localparam logic [3:0] OP_RIGHT = 4'd2;
    localparam logic [3:0] OP_LEFT  = 4'd3;
    localparam logic [3:0] OP_IN    = 4'd4;
    localparam logic [3:0] OP_OUT   = 4'd5;
    localparam logic [3:0] OP_OPEN  = 4'd6;
    localparam logic [3:0] OP_CLOSE = 4'd7;
    localparam logic [3:0] OP_HALT  = 4'd8;

    // program characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // largest run count
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // register index of merge_runs (paddr bit 2)
    localparam logic REG_MERGE_RUNS = 1'b0;

endpackage

// File: sv/bfrl_stack.sv
// ----------------------------------------------------------------------------
// bfrl_stack
// Bounded label stack: labels in a memory, the top entry and the entry below
// it kept in registers so that push and pop can follow in every cycle.
// ----------------------------------------------------------------------------
module bfrl_stack #(
    parameter int DEPTH = 64,
    parameter int LB    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bfrl_pkg::t_stk_ctl    i_ctl,
    input  logic [LB-1:0]         i_push_label,
    output bfrl_pkg::t_stk_status o_status,
    output logic [LB-1:0]         o_top
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [LB-1:0] r_mem [DEPTH];
    logic [LB-1:0] r_rd;
    logic [LB-1:0] r_top;
    logic [LB-1:0] r_fwd;
    logic          r_fwd_sel;
    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    logic [LW-1:0] rd_level;
    logic [LB-1:0] below;

    // level update
    always_comb begin
        n_level = r_level;
        if (i_ctl.clear) begin
            n_level = '0;
        end else if (i_ctl.push) begin
            n_level = r_level + LW'(1);
        end else if (i_ctl.pop) begin
            n_level = r_level - LW'(1);
        end
    end

    // prefetch the entry that will sit below the new top
    assign rd_level = n_level - LW'(2);
    assign below    = r_fwd_sel ? r_fwd : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_fwd_sel <= 1'b0;
        end else begin
            r_level   <= n_level;
            r_fwd_sel <= i_ctl.push;
        end
    end

    // label memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_level[AW-1:0]] <= i_push_label;
        end
        r_rd <= r_mem[rd_level[AW-1:0]];
    end

    // top entry and forwarded old top on push
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top <= i_push_label;
            r_fwd <= r_top;
        end else if (i_ctl.pop) begin
            r_top <= below;
        end
    end

    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == LW'(DEPTH));
    assign o_top          = r_top;

endmodule

// File: sv/bf_token_runlength_loop_labeler.sv
// ----------------------------------------------------------------------------
// bf_token_runlength_loop_labeler
// Turns program bytes into command tokens, merges + - > < into counted runs
// while merge_runs is set, and labels loops through a bounded stack of open labels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  cfg     | input     | psel, penable, pwrite    | paddr, pwdata / prdata
//
// An item is decoded while it sits in the input register and its tokens enter
// the output queue when the item leaves that register, so a token passes the
// input register and the output queue before it can transfer out.
// Items causing zero or one token go at one per cycle while at most two are queued;
// an item's two tokens enter the one-token-per-cycle four-entry queue at once.
// Reset is synchronous and active low; the label memory is not cleared.
// With more than two tokens queued, a waiting item stalls and o_in_ready drops.
// ----------------------------------------------------------------------------
module bf_token_runlength_loop_labeler #(
    parameter int NEST_DEPTH = 64,
    parameter int LABEL_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bfrl_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bfrl_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int QD  = 4;
    localparam int QAW = 2;

    // registers
    logic                    r_merge;
    logic                    r_in_valid;
    bfrl_pkg::t_in_item      r_in;
    logic                    r_pend_valid;
    logic [2:0]              r_pend_op;
    logic [15:0]             r_pend_cnt;
    logic [LABEL_BITS-1:0]   r_next_label;
    bfrl_pkg::t_out_item     r_q [QD];
    logic [QAW-1:0]          r_wp;
    logic [QAW-1:0]          r_rp;
    logic [QAW:0]            r_cnt;

    // next values
    logic                    n_pend_valid;
    logic [2:0]              n_pend_op;
    logic [15:0]             n_pend_cnt;
    logic [LABEL_BITS-1:0]   n_next_label;

    logic                    fire;
    logic                    pop;
    logic                    has_flush;
    logic                    has_main;
    logic                    is_run;
    logic [2:0]              run_op;
    logic [1:0]              n_res;
    logic [1:0]              add_n;
    bfrl_pkg::t_out_item     flush_tok;
    bfrl_pkg::t_out_item     main_tok;
    bfrl_pkg::t_out_item     slot0;
    bfrl_pkg::t_out_item     slot1;
    bfrl_pkg::t_stk_ctl      stk_req;
    bfrl_pkg::t_stk_ctl      stk_ctl;
    bfrl_pkg::t_stk_status   stk_st;
    logic [LABEL_BITS-1:0]   stk_top;
    logic [LABEL_BITS+15:0]  lab_ext;
    logic [LABEL_BITS+15:0]  top_ext;
    logic                    cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bfrl_pkg::REG_MERGE_RUNS);
    assign prdata = (paddr[2] == bfrl_pkg::REG_MERGE_RUNS) ? {31'd0, r_merge} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge <= 1'b1;
        end else if (cfg_wr) begin
            r_merge <= pwdata[0];
        end
    end

    // handshakes
    assign fire        = r_in_valid && (r_cnt <= (QAW+1)'(QD - 2));
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_q[r_rp];

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // low 16 bits of the labels
    assign lab_ext = {16'd0, r_next_label};
    assign top_ext = {16'd0, stk_top};

    // run command decode
    always_comb begin
        is_run = 1'b1;
        run_op = bfrl_pkg::OP_INC[2:0];
        case (r_in.character)
            bfrl_pkg::CH_PLUS:  run_op = bfrl_pkg::OP_INC[2:0];
            bfrl_pkg::CH_MINUS: run_op = bfrl_pkg::OP_DEC[2:0];
            bfrl_pkg::CH_RIGHT: run_op = bfrl_pkg::OP_RIGHT[2:0];
            bfrl_pkg::CH_LEFT:  run_op = bfrl_pkg::OP_LEFT[2:0];
            default:            is_run = 1'b0;
        endcase
    end

    // pending run as a token
    always_comb begin
        flush_tok       = '0;
        flush_tok.op    = {1'b0, r_pend_op};
        flush_tok.count = r_pend_cnt;
    end

    // token generation and state update for the item in the input register
    always_comb begin
        n_pend_valid   = r_pend_valid;
        n_pend_op      = r_pend_op;
        n_pend_cnt     = r_pend_cnt;
        n_next_label   = r_next_label;
        has_flush      = 1'b0;
        has_main       = 1'b0;
        main_tok       = '0;
        main_tok.count = 16'd1;
        stk_req        = '0;
        if (r_in.is_end) begin
            has_flush      = r_pend_valid;
            has_main       = 1'b1;
            main_tok.op    = bfrl_pkg::OP_HALT;
            main_tok.error = !stk_st.empty;
            n_pend_valid   = 1'b0;
            n_pend_op      = '0;
            n_pend_cnt     = 16'd1;
            n_next_label   = '0;
            stk_req.clear  = 1'b1;
        end else begin
            unique case (r_in.character) inside
                bfrl_pkg::CH_SPACE, [bfrl_pkg::CH_TAB:bfrl_pkg::CH_CR]: begin
                end
                bfrl_pkg::CH_OPEN: begin
                    has_flush      = r_pend_valid;
                    n_pend_valid   = 1'b0;
                    n_pend_cnt     = 16'd1;
                    has_main       = 1'b1;
                    main_tok.op    = bfrl_pkg::OP_OPEN;
                    main_tok.label = lab_ext[15:0];
                    main_tok.error = stk_st.full;
                    stk_req.push   = !stk_st.full;
                    n_next_label   = r_next_label + LABEL_BITS'(1);
                end
                bfrl_pkg::CH_CLOSE: begin
                    has_flush    = r_pend_valid;
                    n_pend_valid = 1'b0;
                    n_pend_cnt   = 16'd1;
                    has_main     = 1'b1;
                    main_tok.op  = bfrl_pkg::OP_CLOSE;
                    if (stk_st.empty) begin
                        main_tok.error = 1'b1;
                    end else begin
                        main_tok.label = top_ext[15:0];
                        stk_req.pop    = 1'b1;
                    end
                end
                bfrl_pkg::CH_COMMA, bfrl_pkg::CH_DOT: begin
                    has_flush    = r_pend_valid;
                    n_pend_valid = 1'b0;
                    n_pend_cnt   = 16'd1;
                    has_main     = 1'b1;
                    main_tok.op  = (r_in.character == bfrl_pkg::CH_COMMA) ?
                                   bfrl_pkg::OP_IN : bfrl_pkg::OP_OUT;
                end
                default: begin
                    if (!is_run) begin
                        // unknown byte breaks the run
                        has_flush    = r_pend_valid;
                        n_pend_valid = 1'b0;
                        n_pend_cnt   = 16'd1;
                    end else if (!r_merge) begin
                        has_flush    = r_pend_valid;
                        n_pend_valid = 1'b0;
                        n_pend_cnt   = 16'd1;
                        has_main     = 1'b1;
                        main_tok.op  = {1'b0, run_op};
                    end else if (r_pend_valid && (r_pend_op == run_op) &&
                                 (r_pend_cnt != bfrl_pkg::COUNT_MAX)) begin
                        n_pend_cnt = r_pend_cnt + 16'd1;
                    end else begin
                        has_flush    = r_pend_valid;
                        n_pend_valid = 1'b1;
                        n_pend_op    = run_op;
                        n_pend_cnt   = 16'd1;
                    end
                end
            endcase
        end
    end

    // order the tokens of this item
    always_comb begin
        slot0      = has_flush ? flush_tok : main_tok;
        slot0.last = !(has_flush && has_main);
        slot1      = main_tok;
        slot1.last = 1'b1;
        n_res      = {1'b0, has_flush} + {1'b0, has_main};
        add_n      = fire ? n_res : 2'd0;
        stk_ctl    = fire ? stk_req : '0;
    end

    // run and label state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_op    <= '0;
            r_pend_cnt   <= 16'd1;
            r_next_label <= '0;
        end else if (fire) begin
            r_pend_valid <= n_pend_valid;
            r_pend_op    <= n_pend_op;
            r_pend_cnt   <= n_pend_cnt;
            r_next_label <= n_next_label;
        end
    end

    // label stack
    bfrl_stack #(
        .DEPTH (NEST_DEPTH),
        .LB    (LABEL_BITS)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (stk_ctl),
        .i_push_label (r_next_label),
        .o_status     (stk_st),
        .o_top        (stk_top)
    );

    // output queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QAW'(add_n);
            r_rp  <= r_rp + QAW'(pop);
            r_cnt <= r_cnt + (QAW+1)'(add_n) - (QAW+1)'(pop);
        end
    end

    // output queue entries
    always_ff @(posedge i_clk) begin
        if (add_n != 2'd0) begin
            r_q[r_wp] <= slot0;
        end
        if (add_n == 2'd2) begin
            r_q[r_wp + QAW'(1)] <= slot1;
        end
    end

`ifndef SYNTH
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QD))
        else $error("output queue overfilled");

    // two tokens with no transfer out grow the queue by two
    a_q_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !pop && (n_res == 2'd2)) |=> (r_cnt == $past(r_cnt) + (QAW+1)'(2)))
        else $error("two-token item not queued");

    // halt returns the run and label state to reset
    a_halt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.is_end) |=> (!r_pend_valid && (r_next_label == '0) && stk_st.empty))
        else $error("state not cleared after halt");

    // error flag only on loop and halt tokens
    a_err_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error) |->
        ((o_out_data.op == bfrl_pkg::OP_OPEN) || (o_out_data.op == bfrl_pkg::OP_CLOSE) ||
         (o_out_data.op == bfrl_pkg::OP_HALT)))
        else $error("error flag on a plain token");
`endif

endmodule
